// File: rtl/hdrtm_pkg.sv
// Shared types and constants of the HDR tone mapper.
package hdrtm_pkg;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_REINHARD = 2'd1,
        MODE_ACES     = 2'd2,
        MODE_FILMIC   = 2'd3
    } tone_mode_t;

    localparam int CHAN_W       = 24;
    localparam int SQ_W         = 2 * CHAN_W;
    localparam int LUMA_W       = 40;
    localparam int TERM_W       = 64;
    localparam int QUO_W        = 26;
    localparam int FILM_SCALE_W = 31;
    localparam int PROD_W       = QUO_W + FILM_SCALE_W;
    localparam int LATENCY      = QUO_W + 5;

    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    localparam logic [FILM_SCALE_W-1:0] FILM_SCALE =
        FILM_SCALE_W'((64'd30595 << 32) / 64'd66556);

    localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

    typedef logic [CHAN_W-1:0] chan_t;

endpackage

// File: rtl/hdrtm_luma.sv
// Two-stage luminance sum shared by the three color lanes.
module hdrtm_luma
    import hdrtm_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  chan_t             red,
    input  chan_t             green,
    input  chan_t             blue,
    output logic [LUMA_W-1:0] luma
);

    logic [LUMA_W-1:0] prod_r_reg;
    logic [LUMA_W-1:0] prod_g_reg;
    logic [LUMA_W-1:0] prod_b_reg;
    logic [LUMA_W-1:0] luma_reg;

    // Weight each channel
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_r_reg <= LUMA_W'(red)   * LUMA_W'(LUMA_WR);
            prod_g_reg <= LUMA_W'(green) * LUMA_W'(LUMA_WG);
            prod_b_reg <= LUMA_W'(blue)  * LUMA_W'(LUMA_WB);
        end
    end

    // Sum the weighted channels
    always_ff @(posedge aclk) begin
        if (en) begin
            luma_reg <= prod_r_reg + prod_g_reg + prod_b_reg;
        end
    end

    assign luma = luma_reg;

endmodule

// File: rtl/hdrtm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module hdrtm_div
    import hdrtm_pkg::*;
#(
    parameter int W = 92
)
(
    input  logic             aclk,
    input  logic             en,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    input  logic             filmic_in,
    output logic [QUO_W-1:0] quo,
    output logic             filmic_out
);

    logic [W-1:0]     rem_reg    [QUO_W];
    logic [W-1:0]     den_reg    [QUO_W];
    logic [QUO_W-1:0] quo_reg    [QUO_W];
    logic             filmic_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [W-1:0]     rem_in;
        logic [W-1:0]     den_in;
        logic [QUO_W-1:0] quo_in;
        logic             flag_in;
        logic [W-1:0]     den_sh;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quo_in  = '0;
            assign flag_in = filmic_in;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign flag_in = filmic_reg[k-1];
        end

        // Try subtracting the shifted divisor
        assign den_sh = den_in << BIT;
        assign ge     = (rem_in >= den_sh);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]    <= ge ? (rem_in - den_sh) : rem_in;
                den_reg[k]    <= den_in;
                quo_reg[k]    <= quo_in | (QUO_W'(ge) << BIT);
                filmic_reg[k] <= flag_in;
            end
        end
    end

    assign quo        = quo_reg[QUO_W-1];
    assign filmic_out = filmic_reg[QUO_W-1];

endmodule

// File: rtl/hdrtm_lane.sv
// One color lane: curve terms, operand select, divide, scale and saturate.
module hdrtm_lane
    import hdrtm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int W         = 92
)
(
    input  logic              aclk,
    input  logic              en,
    input  tone_mode_t        mode,
    input  chan_t             chan_in,
    input  logic [LUMA_W-1:0] luma,
    output chan_t             chan_out
);

    localparam int RH_SH = FRAC_BITS + 16;

    // Stage 1: square
    chan_t             c1_reg;
    logic [SQ_W-1:0]   sq1_reg;
    tone_mode_t        mode1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg    <= chan_in;
            sq1_reg   <= SQ_W'(chan_in) * SQ_W'(chan_in);
            mode1_reg <= mode;
        end
    end

    // Stage 2: numerator and denominator polynomials
    chan_t             c2_reg;
    tone_mode_t        mode2_reg;
    logic [TERM_W-1:0] n2_reg, d2_reg, p2_reg, q2_reg;
    logic [TERM_W-1:0] sq_ext, c_one;

    assign sq_ext = TERM_W'(sq1_reg);
    assign c_one  = TERM_W'(c1_reg) << FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg    <= c1_reg;
            mode2_reg <= mode1_reg;
            n2_reg    <= sq_ext * TERM_W'(251) + c_one * TERM_W'(3);
            d2_reg    <= sq_ext * TERM_W'(243) + c_one * TERM_W'(59)
                         + (TERM_W'(14) << (2 * FRAC_BITS));
            p2_reg    <= sq_ext * TERM_W'(84) + c_one * TERM_W'(5);
            q2_reg    <= sq_ext * TERM_W'(30) + c_one * TERM_W'(50)
                         + (TERM_W'(3) << (2 * FRAC_BITS));
        end
    end

    // Stage 3: pick dividend and divisor for the mode
    logic [W-1:0] num_next, den_next;
    logic [W-1:0] num3_reg, den3_reg;
    logic         filmic3_reg;

    always_comb begin
        num_next = W'(c2_reg);
        den_next = W'(1);
        case (mode2_reg)
            MODE_PASS: begin
                num_next = W'(c2_reg);
                den_next = W'(1);
            end
            MODE_REINHARD: begin
                if (luma == '0) begin
                    num_next = '0;
                    den_next = W'(1);
                end else begin
                    num_next = W'(c2_reg) << RH_SH;
                    den_next = (W'(1) << RH_SH) + W'(luma);
                end
            end
            MODE_ACES: begin
                if (n2_reg >= d2_reg) begin
                    num_next = W'(1) << FRAC_BITS;
                    den_next = W'(1);
                end else begin
                    num_next = W'(n2_reg) << FRAC_BITS;
                    den_next = W'(d2_reg);
                end
            end
            MODE_FILMIC: begin
                num_next = W'(p2_reg) << 24;
                den_next = W'(q2_reg);
            end
            default: begin
                num_next = W'(c2_reg);
                den_next = W'(1);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num3_reg    <= num_next;
            den3_reg    <= den_next;
            filmic3_reg <= (mode2_reg == MODE_FILMIC);
        end
    end

    // Divide
    logic [QUO_W-1:0] quo;
    logic             filmic_div;

    hdrtm_div #(.W(W)) u_div (
        .aclk       (aclk),
        .en         (en),
        .num        (num3_reg),
        .den        (den3_reg),
        .filmic_in  (filmic3_reg),
        .quo        (quo),
        .filmic_out (filmic_div)
    );

    // White-point scale
    logic [PROD_W-1:0] prod_reg;
    logic [QUO_W-1:0]  quo_post_reg;
    logic              filmic_post_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg        <= PROD_W'(quo) * PROD_W'(FILM_SCALE);
            quo_post_reg    <= quo;
            filmic_post_reg <= filmic_div;
        end
    end

    // Shift down and saturate
    logic [PROD_W-1:0] res;
    chan_t             out_reg;

    assign res = filmic_post_reg ? (prod_reg >> (56 - FRAC_BITS))
                                 : PROD_W'(quo_post_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= (res > PROD_W'(CHAN_MAX)) ? CHAN_MAX : res[CHAN_W-1:0];
        end
    end

    assign chan_out = out_reg;

endmodule

// File: rtl/hdr_tone_mapper_top.sv
// Top level of the HDR tone mapper: three color lanes and shared luminance.
//
// One linear RGB pixel (unsigned Q8.16 per channel) enters per transaction on
// the s_ channel; one tone-mapped pixel leaves per transaction on the m_
// channel. cfg_wr_en/cfg_wr_data write the 2-bit mode register (pass-through,
// Reinhard, ACES, filmic); write it only while the pipeline is empty.
// Throughput: one pixel per cycle while m_ready does not stall the output. Latency:
// 31 register stages, set by the 26-stage restoring divider in each lane plus three
// stages before it and two after it (scale, saturate/output register).
// The three lanes run side by side; the luminance sum feeds all of them and
// the output register joins the three channels into one result.
// Reset (aresetn low, synchronous) empties the pipeline and sets the mode to
// pass-through. When the receiver holds m_ready low with a result waiting,
// the whole pipeline freezes and s_ready drops until the result is taken.
module hdr_tone_mapper_top
    import hdrtm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_red_in,
    input  logic [23:0] s_green_in,
    input  logic [23:0] s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_red_out,
    output logic [23:0] m_green_out,
    output logic [23:0] m_blue_out
);

    localparam int W = FRAC_BITS + 76;

    tone_mode_t          mode_reg;
    logic [LATENCY-1:0]  vpipe_reg;
    logic                en;
    logic [LUMA_W-1:0]   luma;

    // Advance whenever the output slot is free or being drained
    assign en      = !vpipe_reg[LATENCY-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vpipe_reg[LATENCY-1];

    // Hold the mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PASS;
        end else if (cfg_wr_en) begin
            mode_reg <= tone_mode_t'(cfg_wr_data);
        end
    end

    // Track which stages carry a transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpipe_reg <= '0;
        end else if (en) begin
            vpipe_reg <= {vpipe_reg[LATENCY-2:0], s_valid};
        end
    end

    hdrtm_luma u_luma (
        .aclk  (aclk),
        .en    (en),
        .red   (s_red_in),
        .green (s_green_in),
        .blue  (s_blue_in),
        .luma  (luma)
    );

    hdrtm_lane #(.FRAC_BITS(FRAC_BITS), .W(W)) u_lane_r (
        .aclk     (aclk),
        .en       (en),
        .mode     (mode_reg),
        .chan_in  (s_red_in),
        .luma     (luma),
        .chan_out (m_red_out)
    );

    hdrtm_lane #(.FRAC_BITS(FRAC_BITS), .W(W)) u_lane_g (
        .aclk     (aclk),
        .en       (en),
        .mode     (mode_reg),
        .chan_in  (s_green_in),
        .luma     (luma),
        .chan_out (m_green_out)
    );

    hdrtm_lane #(.FRAC_BITS(FRAC_BITS), .W(W)) u_lane_b (
        .aclk     (aclk),
        .en       (en),
        .mode     (mode_reg),
        .chan_in  (s_blue_in),
        .luma     (luma),
        .chan_out (m_blue_out)
    );

    // Checks
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    a_accept_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vpipe_reg[0])
        else $error("accepted transaction not tracked");

endmodule

// File: tb/sv/hdr_tone_mapper_checker.sv
// Checker for the HDR tone mapper: predicts each pixel and compares results.
`timescale 1ns / 1ps
module hdr_tone_mapper_checker
    import hdrtm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [23:0] s_red_in,
    input  logic [23:0] s_green_in,
    input  logic [23:0] s_blue_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [23:0] m_red_out,
    input  logic [23:0] m_green_out,
    input  logic [23:0] m_blue_out,
    output int          error_count,
    output int          pixels_pending
);

    typedef logic [127:0] wide_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    localparam wide_t ONE_W = wide_t'(1) << FRAC_BITS;
    localparam wide_t WHITE_SCALE = (wide_t'(30595) << 32) / wide_t'(66556);

    tone_mode_t mode_shadow = MODE_PASS;
    pixel_t     pixel_queue[$];
    int         err_count_reg = 0;

    assign error_count = err_count_reg;

    // Clamp to the channel full scale
    function automatic chan_t clamp_chan(wide_t v);
        return (v > wide_t'(CHAN_MAX)) ? CHAN_MAX : chan_t'(v);
    endfunction

    function automatic chan_t aces_chan(chan_t c);
        wide_t cw, num, den;
        cw  = wide_t'(c);
        num = cw * (251 * cw + 3 * ONE_W);
        den = cw * (243 * cw + 59 * ONE_W) + 14 * ONE_W * ONE_W;
        if (num >= den) return clamp_chan(ONE_W);
        return clamp_chan((num << FRAC_BITS) / den);
    endfunction

    function automatic chan_t filmic_chan(chan_t c);
        wide_t cw, num, den, ratio;
        cw    = wide_t'(c);
        num   = cw * (84 * cw + 5 * ONE_W);
        den   = 30 * cw * cw + 50 * cw * ONE_W + 3 * ONE_W * ONE_W;
        ratio = (num << 24) / den;
        return clamp_chan((ratio * WHITE_SCALE) >> (56 - FRAC_BITS));
    endfunction

    // Compute the tone-mapped pixel for the current mode
    function automatic pixel_t map_pixel(tone_mode_t mode, pixel_t px);
        pixel_t res;
        wide_t  luma, base;
        case (mode)
            MODE_REINHARD: begin
                luma = wide_t'(LUMA_WR) * px.red + wide_t'(LUMA_WG) * px.green
                     + wide_t'(LUMA_WB) * px.blue;
                base = ONE_W << 16;
                if (luma == 0) begin
                    res = '0;
                end else begin
                    res.red   = clamp_chan((wide_t'(px.red) * base) / (base + luma));
                    res.green = clamp_chan((wide_t'(px.green) * base) / (base + luma));
                    res.blue  = clamp_chan((wide_t'(px.blue) * base) / (base + luma));
                end
            end
            MODE_ACES: begin
                res.red   = aces_chan(px.red);
                res.green = aces_chan(px.green);
                res.blue  = aces_chan(px.blue);
            end
            MODE_FILMIC: begin
                res.red   = filmic_chan(px.red);
                res.green = filmic_chan(px.green);
                res.blue  = filmic_chan(px.blue);
            end
            default: res = px;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH %s at %0t", msg, $time);
        err_count_reg++;
    endtask

    // Track mode, queue predictions and compare each result transaction
    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            mode_shadow    <= MODE_PASS;
            pixels_pending <= 0;
        end else begin
            if (cfg_wr_en) mode_shadow <= tone_mode_t'(cfg_wr_data);
            if (s_valid && s_ready)
                pixel_queue = {pixel_queue,
                               map_pixel(mode_shadow, {s_red_in, s_green_in, s_blue_in})};
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("unexpected result");
                end else begin
                    want = pixel_queue.pop_front();
                    if (m_red_out !== want.red)
                        report_mismatch($sformatf("red: got %h expected %h",
                                                  m_red_out, want.red));
                    if (m_green_out !== want.green)
                        report_mismatch($sformatf("green: got %h expected %h",
                                                  m_green_out, want.green));
                    if (m_blue_out !== want.blue)
                        report_mismatch($sformatf("blue: got %h expected %h",
                                                  m_blue_out, want.blue));
                end
            end
            pixels_pending <= pixel_queue.size();
        end
    end

endmodule

// File: tb/sv/hdr_tone_mapper_top_tb.sv
// Testbench top for the HDR tone mapper: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module hdr_tone_mapper_top_tb
    import hdrtm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 190;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_red_in = '0;
    logic [23:0] s_green_in = '0;
    logic [23:0] s_blue_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_red_out;
    logic [23:0] m_green_out;
    logic [23:0] m_blue_out;
    int          error_count;
    int          pixels_pending;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hdr_tone_mapper_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out)
    );

    hdr_tone_mapper_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .error_count(error_count), .pixels_pending(pixels_pending)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(7, 0);
    endfunction

    // Draw a channel value: full range, up to 4.0, tiny, an extreme or 0.25 to 32.0
    function automatic chan_t draw_chan();
        case ($urandom_range(5, 0))
            0, 1: return chan_t'($urandom);
            2: return chan_t'($urandom_range(4 << 16, 0));
            3: return chan_t'($urandom_range(255, 0));
            4: return ($urandom_range(1, 0) != 0) ? CHAN_MAX : '0;
            default: return chan_t'($urandom_range(32 << 16, 1 << 14));
        endcase
    endfunction

    // Hold one pixel transaction until accepted, then idle per the drawn gap
    task automatic send_pixel(chan_t r, chan_t g, chan_t b);
        bit ok;
        int gap;
        s_valid    <= 1'b1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_mode(tone_mode_t mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_directed();
        send_pixel('0, '0, '0);
        send_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX);
        send_pixel(CHAN_MAX, '0, '0);
        send_pixel('0, CHAN_MAX, '0);
        send_pixel('0, '0, CHAN_MAX);
        send_pixel(24'h010000, 24'h010000, 24'h010000);
        send_pixel(24'h000001, 24'h000001, 24'h000001);
        send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_pixel(24'h555555, 24'hAAAAAA, 24'h555555);
        send_pixel(24'h0B3333, 24'h008000, 24'h000000);
    endtask

    // Receiver: draw a stall per result, keep ready high on zero stalls
    initial begin
        bit ok;
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                ok = m_valid;
                @(posedge aclk);
            end while (!ok);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        tone_mode_t mode;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pixels in the reset mode, then in each mode explicitly
        send_directed();
        drain_pipeline();
        for (int m = 0; m < 4; m++) begin
            write_mode(tone_mode_t'(m));
            send_directed();
            drain_pipeline();
        end

        // Random phases over all modes, some without idling
        for (int phase = 0; phase < 8; phase++) begin
            mode = (phase < 4) ? tone_mode_t'(3 - phase) : tone_mode_t'($urandom_range(3, 0));
            write_mode(mode);
            no_idle = (phase % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(9, 0) == 0)
                    send_pixel('0, '0, '0);
                else
                    send_pixel(draw_chan(), draw_chan(), draw_chan());
            end
            no_idle = 1'b0;
            drain_pipeline();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/hdrtm_pkg.sv
rtl/hdrtm_luma.sv
rtl/hdrtm_div.sv
rtl/hdrtm_lane.sv
rtl/hdr_tone_mapper_top.sv
tb/sv/hdr_tone_mapper_checker.sv
tb/sv/hdr_tone_mapper_top_tb.sv
